### rtl/ship_lite_stream_replacement_macros.svh
// assertion macros for the replacement block
`ifndef SHIP_LITE_STREAM_REPLACEMENT_MACROS_SVH
`define SHIP_LITE_STREAM_REPLACEMENT_MACROS_SVH
// implication checked every edge outside reset
`define SLSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define SLSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/slsr_pkg.sv
// shared types and constants of the replacement block
package slsr_pkg;
    localparam int SETS_DEF = 2048;
    localparam int WAYS_DEF = 16;
    localparam int CNTS_DEF = 16;
    localparam int ADDR_W = 48;
    localparam int SIG_W = 6;
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UPDATE = 1'b1;
    localparam logic [3:0] THR_RESET = 4'd5;
    localparam logic [11:0] STRIDE_RESET = 12'd64;
    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_STRIDE = 2'd1;

    typedef struct packed {
        logic       op;
        logic [10:0] set_index;
        logic [3:0] way;
        logic [47:0] address;
        logic [5:0] signature;
        logic       hit;
        logic [3:0] random_nibble;
    } item_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       streaming;
    } result_t;
endpackage

### rtl/slsr_ram.sv
// generic ram with one write port and one registered read port
module slsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/slsr_front.sv
// input stage and two entry queue
module slsr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slsr_pkg::item_t       in_item,
    output logic                  q_valid,
    input  logic                  q_ready,
    output slsr_pkg::item_t       q_item
);
    import slsr_pkg::*;

    item_t      ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = ent_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= in_item;
        end
    end
endmodule

### rtl/slsr_back.sv
// read modify write engine for set metadata
module slsr_back #(
    parameter int NUM_SETS = slsr_pkg::SETS_DEF,
    parameter int NUM_WAYS = slsr_pkg::WAYS_DEF,
    parameter int COUNTERS_PER_SET = slsr_pkg::CNTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  slsr_pkg::item_t       q_item,
    input  logic [3:0]            thr,
    input  logic [11:0]           stride,
    output logic                  out_valid,
    input  logic                  out_ready,
    output slsr_pkg::result_t     out_res,
    output logic                  busy
);
    import slsr_pkg::*;

    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW = $clog2(NUM_WAYS);
    localparam int CW = (COUNTERS_PER_SET > 1) ? $clog2(COUNTERS_PER_SET) : 1;
    localparam int LW = NUM_WAYS * 8;
    localparam int RW = COUNTERS_PER_SET * 2;
    localparam int DW = LW + RW + ADDR_W + 5;
    localparam int SR_SETS = (NUM_SETS > 1) ? NUM_SETS : 2;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CLR = 2'd2;

    logic [1:0]    st_reg, st_next;
    logic [SW-1:0] clr_reg;
    item_t         it_reg;
    logic          ov_reg;
    result_t       res_reg;
    logic [SW-1:0] set_idx;
    logic          we;
    logic [SW-1:0] waddr;
    logic [DW-1:0] wdata, rdata, nd;
    logic [DW-1:0] rst_word;
    logic [1:0]    rr [NUM_WAYS];
    logic [SIG_W-1:0] rs [NUM_WAYS];
    logic [1:0]    rc [COUNTERS_PER_SET];
    logic [ADDR_W-1:0] la;
    logic signed [4:0] sc, sc_n;
    logic [ADDR_W-1:0] stp;
    logic [1:0]    top, bump;
    logic [WW-1:0] vw;
    logic [WW-1:0] w;
    logic [CW-1:0] ix, oix;
    logic [1:0]    cdec;
    logic          strm;
    result_t       res_n;

    assign set_idx = (NUM_SETS > 1) ? SW'(q_item.set_index % NUM_SETS) : '0;
    assign busy = (st_reg != ST_IDLE) || q_valid || ov_reg;
    assign q_ready = (st_reg == ST_IDLE) && !(ov_reg && !out_ready);
    assign out_valid = ov_reg;
    assign out_res = res_reg;

    always_comb
    begin
        rst_word = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            rst_word[i*8 +: 2] = 2'd3;
        end
        for (int i = 0; i < COUNTERS_PER_SET; i++)
        begin
            rst_word[LW + i*2 +: 2] = 2'd1;
        end
    end

    slsr_ram #(.WIDTH(DW), .DEPTH(SR_SETS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(set_idx), .rdata(rdata)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            rr[i] = rdata[i*8 +: 2];
            rs[i] = rdata[i*8 + 2 +: SIG_W];
        end
        for (int i = 0; i < COUNTERS_PER_SET; i++)
        begin
            rc[i] = rdata[LW + i*2 +: 2];
        end
        la = rdata[LW + RW +: ADDR_W];
        sc = $signed(rdata[LW + RW + ADDR_W +: 5]);
        w = WW'(it_reg.way % NUM_WAYS);
        ix = (COUNTERS_PER_SET > 1) ? CW'(it_reg.signature % COUNTERS_PER_SET) : '0;
        oix = (COUNTERS_PER_SET > 1) ? CW'(rs[w] % COUNTERS_PER_SET) : '0;
        stp = (it_reg.address >= la) ? (it_reg.address - la) : (la - it_reg.address);
        if (stp == {36'd0, stride})
        begin
            sc_n = (sc < 5'sd8) ? sc + 5'sd1 : sc;
        end
        else
        begin
            sc_n = (sc > -5'sd8) ? sc - 5'sd1 : sc;
        end
        strm = (sc_n >= $signed({1'b0, thr}));
        top = 2'd0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (rr[i] > top)
            begin
                top = rr[i];
            end
        end
        bump = 2'd3 - top;
        nd = rdata;
        vw = '0;
        res_n = '0;
        cdec = 2'd0;
        if (it_reg.op == OP_QUERY)
        begin
            for (int i = NUM_WAYS - 1; i >= 0; i--)
            begin
                nd[i*8 +: 2] = rr[i] + bump;
                if (rr[i] + bump == 2'd3)
                begin
                    vw = WW'(i);
                end
            end
            res_n.victim_way = 4'(vw);
        end
        else
        begin
            nd[LW + RW +: ADDR_W] = it_reg.address;
            nd[LW + RW + ADDR_W +: 5] = sc_n;
            res_n.streaming = strm;
            if (it_reg.hit)
            begin
                nd[w*8 +: 2] = 2'd0;
                if (rc[ix] != 2'd3)
                begin
                    nd[LW + ix*2 +: 2] = rc[ix] + 2'd1;
                end
            end
            else
            begin
                if (rc[oix] != 2'd0)
                begin
                    nd[LW + oix*2 +: 2] = rc[oix] - 2'd1;
                end
                cdec = nd[LW + ix*2 +: 2];
                nd[w*8 + 2 +: SIG_W] = it_reg.signature;
                if (strm)
                begin
                    nd[w*8 +: 2] = (it_reg.random_nibble == 4'd0) ? 2'd2 : 2'd3;
                end
                else
                begin
                    nd[w*8 +: 2] = (cdec <= 2'd1) ? 2'd3 : 2'd2;
                end
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        we = 1'b0;
        waddr = SW'(it_reg.set_index % NUM_SETS);
        wdata = nd;
        unique case (st_reg)
            ST_CLR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = rst_word;
                if (clr_reg == SW'(NUM_SETS - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                we = 1'b1;
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (st_reg == ST_READ)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            it_reg <= q_item;
        end
        if (st_reg == ST_READ)
        begin
            res_reg <= res_n;
        end
    end
endmodule

### rtl/ship_lite_stream_replacement.sv
// top level of the replacement block
// input channel: in_valid/in_ready with operation, set_index, way, address,
// signature, hit and random_nibble; one transfer per query or update
// output channel: out_valid/out_ready with victim_way and streaming, exactly
// one result transfer per input transfer, in order
// config: apb port, stream_threshold at 0x0, stride_bytes at 0x4
// the set word of the queue head item is read from the metadata ram, then
// written back in the read state as the result is registered
// a new item is taken only when idle, after the last one is written back
// after reset a clearing pass writes every set, during which items wait in
// the two entry input queue
// a stalled receiver holds the result; the queue keeps taking up to two items
module ship_lite_stream_replacement #(
    parameter int NUM_SETS = slsr_pkg::SETS_DEF,
    parameter int NUM_WAYS = slsr_pkg::WAYS_DEF,
    parameter int COUNTERS_PER_SET = slsr_pkg::CNTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [10:0] set_index,
    input  logic [3:0]  way,
    input  logic [47:0] address,
    input  logic [5:0]  signature,
    input  logic        hit,
    input  logic [3:0]  random_nibble,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  victim_way,
    output logic        streaming,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slsr_pkg::*;
`include "ship_lite_stream_replacement_macros.svh"

    item_t       in_item, q_item;
    result_t     res;
    logic        q_valid, q_ready, busy;
    logic [3:0]  thr_reg;
    logic [11:0] stride_reg;

    assign in_item = '{operation, set_index, way, address, signature, hit, random_nibble};
    assign victim_way = res.victim_way;
    assign streaming = res.streaming;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            stride_reg <= STRIDE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_STRIDE[0])
            begin
                stride_reg <= pwdata[11:0];
            end
            else
            begin
                thr_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_THR[0])
        begin
            prdata = {28'd0, thr_reg};
        end
        else
        begin
            prdata = {20'd0, stride_reg};
        end
    end

    slsr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    slsr_back #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .COUNTERS_PER_SET(COUNTERS_PER_SET)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .thr(thr_reg), .stride(stride_reg), .out_valid(out_valid),
        .out_ready(out_ready), .out_res(res), .busy(busy)
    );

    `SLSR_ASSERT_IMP(a_query_no_stream, out_valid && streaming, victim_way == 4'd0)
    `SLSR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(victim_way))
    `SLSR_ASSERT_IMP(a_busy_out, out_valid, busy)
endmodule

### test/ship_lite_stream_replacement_tb.sv
// testbench for the replacement block: directed table, random phases, scoreboard
module ship_lite_stream_replacement_tb;
    import slsr_pkg::*;

    localparam int SETS = SETS_DEF;
    localparam int WAYS = WAYS_DEF;
    localparam int CNTS = CNTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [47:0] address;
    logic [5:0]  signature;
    logic        hit;
    logic [3:0]  random_nibble;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  victim_way;
    logic        streaming;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ship_lite_stream_replacement dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .set_index(set_index), .way(way), .address(address),
        .signature(signature), .hit(hit), .random_nibble(random_nibble),
        .out_valid(out_valid), .out_ready(out_ready),
        .victim_way(victim_way), .streaming(streaming),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // mirror of the policy state
    logic [1:0]  rrpv_m  [0:SETS-1][0:WAYS-1];
    logic [5:0]  sig_m   [0:SETS-1][0:WAYS-1];
    logic [1:0]  reuse_m [0:SETS-1][0:CNTS-1];
    logic [47:0] last_addr_m [0:SETS-1];
    int          score_m [0:SETS-1];
    logic [3:0]  thr_m;
    logic [11:0] stride_m;

    result_t expected_results[$];
    row_t    dir_rows[$];
    int      errors;
    int      cycles;
    int      results_seen;
    bit      quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void clear_policy();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                rrpv_m[s][w] = 2'd3;
                sig_m[s][w] = '0;
            end
            for (int c = 0; c < CNTS; c++)
                reuse_m[s][c] = 2'd1;
            last_addr_m[s] = '0;
            score_m[s] = 0;
        end
        thr_m = THR_RESET;
        stride_m = STRIDE_RESET;
    endfunction

    function automatic result_t predict_result(item_t it);
        result_t     r;
        int          s;
        int          w;
        int          top;
        bit          found;
        bit          str;
        logic [47:0] step;
        logic [3:0]  ci;
        logic [3:0]  oi;
        r = '0;
        s = it.set_index;
        w = it.way;
        if (it.op == OP_QUERY)
        begin
            top = 0;
            found = 1'b0;
            for (int i = 0; i < WAYS; i++)
                if (rrpv_m[s][i] > top) top = rrpv_m[s][i];
            for (int i = 0; i < WAYS; i++)
                rrpv_m[s][i] = rrpv_m[s][i] + 2'(3 - top);
            for (int i = 0; i < WAYS; i++)
                if (!found && rrpv_m[s][i] == 2'd3)
                begin
                    found = 1'b1;
                    r.victim_way = 4'(i);
                end
            return r;
        end
        step = (it.address >= last_addr_m[s]) ? it.address - last_addr_m[s]
                                               : last_addr_m[s] - it.address;
        if (step == {36'd0, stride_m})
        begin
            if (score_m[s] < 8) score_m[s]++;
        end
        else if (score_m[s] > -8)
            score_m[s]--;
        last_addr_m[s] = it.address;
        str = score_m[s] >= int'(thr_m);
        ci = it.signature[3:0];
        if (it.hit)
        begin
            rrpv_m[s][w] = 2'd0;
            if (reuse_m[s][ci] < 2'd3) reuse_m[s][ci]++;
        end
        else
        begin
            oi = sig_m[s][w][3:0];
            if (reuse_m[s][oi] > 2'd0) reuse_m[s][oi]--;
            sig_m[s][w] = it.signature;
            if (str)
                rrpv_m[s][w] = (it.random_nibble == 4'd0) ? 2'd2 : 2'd3;
            else
                rrpv_m[s][w] = (reuse_m[s][ci] <= 2'd1) ? 2'd3 : 2'd2;
        end
        r.streaming = str;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    task automatic config_write(logic [1:0] reg_idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'({reg_idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_THR) thr_m = value[3:0];
        else stride_m = value[11:0];
    endtask

    // one transfer on the input side; typed rows override the prediction
    task automatic send_item(item_t it, bit typed, result_t res);
        int      gap;
        result_t r;
        in_valid <= 1'b1;
        operation <= it.op;
        set_index <= it.set_index;
        way <= it.way;
        address <= it.address;
        signature <= it.signature;
        hit <= it.hit;
        random_nibble <= it.random_nibble;
        do @(posedge clk); while (!in_ready);
        r = predict_result(it);
        expected_results.push_back(typed ? res : r);
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic row_t mk_row(logic op, int s, int w, logic [47:0] a, int sg,
                                    logic h, int nib, bit typed, int vw, logic st);
        row_t rw;
        rw.it.op = op;
        rw.it.set_index = 11'(s);
        rw.it.way = 4'(w);
        rw.it.address = a;
        rw.it.signature = 6'(sg);
        rw.it.hit = h;
        rw.it.random_nibble = 4'(nib);
        rw.typed = typed;
        rw.res.victim_way = 4'(vw);
        rw.res.streaming = st;
        return rw;
    endfunction

    function automatic item_t random_item(int pool[4]);
        item_t it;
        int    s;
        it.op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_UPDATE;
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SETS - 1)
                                         : pool[$urandom_range(0, 3)];
        it.set_index = 11'(s);
        it.way = 4'($urandom);
        it.signature = 6'($urandom);
        it.hit = 1'($urandom);
        it.random_nibble = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom);
        case ($urandom_range(0, 7))
            0: it.address = {16'($urandom), 32'($urandom)};
            1: it.address = last_addr_m[s];
            2, 3, 4: it.address = last_addr_m[s] + {36'd0, stride_m};
            default: it.address = last_addr_m[s] - {36'd0, stride_m};
        endcase
        return it;
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n) break;
        end
        forever
        begin
            int stall;
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected transfer victim_way", victim_way, 0);
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (victim_way !== e.victim_way)
                    report_mismatch("victim_way", victim_way, e.victim_way);
                if (streaming !== e.streaming)
                    report_mismatch("streaming", streaming, e.streaming);
            end
            // long hold so the input queue fills and stalls
            if (results_seen == 150)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
            end
        end
    end

    initial
    begin
        int      pool[4];
        result_t none;
        logic [3:0]  thr_set[6];
        logic [11:0] stride_set[6];
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_QUERY;
        set_index = '0;
        way = '0;
        address = '0;
        signature = '0;
        hit = 1'b0;
        random_nibble = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        quiet = 1'b0;
        none = '0;
        clear_policy();
        thr_set = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd2, 4'd5};
        stride_set = '{12'd64, 12'd1, 12'd4095, 12'd0, 12'd64, 12'd64};

        dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 48'd0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 2047, 15, '1, 63, 1, 15, 1, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 5, 15, 48'h40, 63, 1, 15, 1, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 5, 0, 48'd0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 9, 0, 48'd0, 0, 1, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 9, 0, 48'd0, 0, 0, 0, 1, 1, 0));
        for (int k = 1; k <= 4; k++)
            dir_rows.push_back(mk_row(OP_UPDATE, 7, k, 48'(64 * k), k, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 7, 5, 48'd320, 21, 0, 0, 1, 0, 1));
        dir_rows.push_back(mk_row(OP_UPDATE, 7, 6, 48'd384, 37, 0, 5, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 7, 5, 48'd320, 21, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 7, 15, 48'hFFFF_FFFF_FFFF, 63, 0, 15, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 7, 3, 48'd0, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 9, 0, 48'd64, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UPDATE, 9, 0, 48'd128, 16, 0, 9, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 9, 0, 48'd0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_QUERY, 1024, 10, 48'h5555_5555_5555, 42, 0, 10, 1, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            config_write(REG_THR, 32'(thr_set[ph]));
            config_write(REG_STRIDE, 32'(stride_set[ph]));
            quiet = (ph == 4);
            pool[0] = 0;
            pool[1] = SETS - 1;
            pool[2] = $urandom_range(0, SETS - 1);
            pool[3] = $urandom_range(0, SETS - 1);
            for (int n = 0; n < 75; n++)
                send_item(random_item(pool), 1'b0, none);
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
